### rtl/rmt_pkg.sv
// Shared constants for the running median tracker.
package rmt_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W = 11;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_PLACE = 6'b000100,
    ST_MED0  = 6'b001000,
    ST_MED1  = 6'b010000,
    ST_MED2  = 6'b100000
  } state_e;

endpackage

### rtl/rmt_ram.sv
// Generic simple dual-port RAM with registered read.
module rmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/running_median_tracker_unit.sv
// Top level of the running median tracker: sorted store, insert sequencer, median read.
//
// Usage:
//   Sample channel (sample_valid_i / sample_ready_o / sample_value_i) takes one
//   32-bit unsigned request at a time. Result channel (result_valid_o /
//   result_ready_i) returns one result per request: the median of all values
//   held, the count held and an overflow flag set when the store was full and
//   the value was dropped.
//   The values sit in ascending order in one RAM of CAPACITY words. Insertion
//   walks down from the top, one read-compare-write per cycle, moving each
//   larger value up one place; the RAM's single read and write port set the
//   pace. When the store is full the value skips insertion and goes straight
//   to the median read. The next request is taken once the result has been
//   loaded into the output register.
//   Reads always address below the pending write, so no forwarding is needed.
//   Reset clears the count, the state and the result valid flag; the RAM is
//   never cleared, as only written entries are read. No clearing pass is run.
//   A stalled receiver holds the result register; the block waits with its
//   finished median until the register frees, and takes no new request.
module running_median_tracker_unit
  import rmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sample_valid_i,
  output logic                 sample_ready_o,
  input  logic [VALUE_W-1:0]   sample_value_i,
  output logic                 result_valid_o,
  input  logic                 result_ready_i,
  output logic [VALUE_W-1:0]   median_value_o,
  output logic [OUT_CNT_W-1:0] stored_count_o,
  output logic                 overflow_o
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic                 ovf_q, ovf_d;
  logic [VALUE_W-1:0]   hi_q, hi_d;
  logic                 rv_q, rv_d;
  logic [VALUE_W-1:0]   med_q, med_d;
  logic [OUT_CNT_W-1:0] cnt_out_q, cnt_out_d;
  logic                 ovf_out_q, ovf_out_d;

  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  logic [VALUE_W-1:0]   wdata;
  logic                 re;
  logic [ADDR_W-1:0]    raddr;
  logic [VALUE_W-1:0]   rdata;

  logic [ADDR_W-1:0]    half;
  logic [VALUE_W:0]     pair_sum;
  logic                 accept;

  rmt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sample_ready_o = (state_q == ST_IDLE);
  assign accept         = sample_valid_i && sample_ready_o;
  assign half           = ADDR_W'(count_q >> 1);
  // 33-bit sum keeps the carry of the middle pair
  assign pair_sum       = {1'b0, hi_q} + {1'b0, rdata};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    val_d     = val_q;
    ovf_d     = ovf_q;
    hi_d      = hi_q;
    rv_d      = rv_q;
    med_d     = med_q;
    cnt_out_d = cnt_out_q;
    ovf_out_d = ovf_out_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = val_q;
    re        = 1'b0;
    raddr     = ADDR_W'(idx_q - 1'b1);

    // drop the result once taken
    if (rv_q && result_ready_i) begin
      rv_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = sample_value_i;
          if (count_q >= CNT_W'(CAPACITY)) begin
            ovf_d   = 1'b1;
            state_d = ST_MED0;
          end else begin
            ovf_d = 1'b0;
            idx_d = ADDR_W'(count_q);
            if (count_q == '0) begin
              state_d = ST_PLACE;
            end else begin
              // fetch the current top element
              re      = 1'b1;
              raddr   = ADDR_W'(count_q - 1'b1);
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rdata > val_q) begin
          // move the larger value up one place
          we    = 1'b1;
          waddr = idx_q;
          wdata = rdata;
          idx_d = ADDR_W'(idx_q - 1'b1);
          if (idx_q == ADDR_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = ADDR_W'(idx_q - 2'd2);
          end
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = val_q;
        count_d = CNT_W'(count_q + 1'b1);
        state_d = ST_MED0;
      end
      ST_MED0: begin
        re      = 1'b1;
        raddr   = half;
        state_d = ST_MED1;
      end
      ST_MED1: begin
        hi_d    = rdata;
        re      = !count_q[0];
        raddr   = ADDR_W'(half - 1'b1);
        state_d = ST_MED2;
      end
      ST_MED2: begin
        // hold the median until the output register is free
        if (!rv_q || result_ready_i) begin
          med_d     = count_q[0] ? hi_q : pair_sum[VALUE_W:1];
          cnt_out_d = OUT_CNT_W'(count_q);
          ovf_out_d = ovf_q;
          rv_d      = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    val_q     <= val_d;
    ovf_q     <= ovf_d;
    hi_q      <= hi_d;
    med_q     <= med_d;
    cnt_out_q <= cnt_out_d;
    ovf_out_q <= ovf_out_d;
  end

  assign result_valid_o = rv_q;
  assign median_value_o = med_q;
  assign stored_count_o = cnt_out_q;
  assign overflow_o     = ovf_out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_SCAN || state_q == ST_PLACE))
    else $error("store written outside insertion");

  a_place_incr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PLACE |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("count not advanced on placement");

  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MED2 && ovf_q) |-> count_q == CNT_W'(CAPACITY))
    else $error("overflow raised with room in store");

endmodule
